>>> rtl/otq_pkg.sv
// Package for the ordered timer queue: payload structs, operation and state
// codes, status codes and the saturating add helper.
// No dependencies.
package otq_pkg;

    // Default number of timer slots.
    localparam int SLOTS_DEF = 16;
    // Most expired timers handled by one process item.
    localparam int MAX_RESULTS = 16;

    // Mode field codes.
    localparam logic [1:0] MODE_REGISTER = 2'd0;
    localparam logic [1:0] MODE_CANCEL   = 2'd1;
    localparam logic [1:0] MODE_QUERY    = 2'd2;
    localparam logic [1:0] MODE_PROCESS  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] now_us;
        logic [63:0] period_us;
        logic        repeat_req;
        logic [3:0]  handle_in;
    } in_t;

    typedef struct packed {
        logic [3:0]  handle_out;
        logic        at_front;
        logic [63:0] remaining_us;
        logic        expired_valid;
        logic [1:0]  status;
        logic        last;
    } out_t;

    typedef enum logic [1:0] {
        OP_REGISTER,
        OP_CANCEL,
        OP_QUERY,
        OP_PROCESS
    } op_t;

    // Classified command handed from the front end to the engine.
    typedef struct packed {
        op_t         op;
        logic [63:0] now_us;
        logic [63:0] period_us;
        logic        repeat_req;
        logic [3:0]  handle;
        logic        in_range;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG_ADD,
        S_SCAN,
        S_FINISH,
        S_P_UPD,
        S_OUT
    } state_t;

    // Unsigned add that saturates at all ones.
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

endpackage

>>> rtl/otq_front.sv
// Front end of the ordered timer queue: a two-entry command queue that
// accepts items and classifies the mode and the cancel handle range.
// Depends on otq_pkg.
module otq_front import otq_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic cmd_valid,
    input  logic cmd_ready,
    output cmd_t cmd
);

    cmd_t       q_mem_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    logic [6:0] h7;
    cmd_t       cls;

    // Classify the incoming item.
    always_comb begin
        h7           = 7'(s_data.handle_in);
        cls.now_us     = s_data.now_us;
        cls.period_us  = s_data.period_us;
        cls.repeat_req = s_data.repeat_req;
        cls.handle     = s_data.handle_in;
        cls.in_range   = (h7 < 7'(SLOTS));
        unique case (s_data.mode)
            MODE_REGISTER: cls.op = OP_REGISTER;
            MODE_CANCEL:   cls.op = OP_CANCEL;
            MODE_QUERY:    cls.op = OP_QUERY;
            default:       cls.op = OP_PROCESS;
        endcase
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Queue pointers and fill count.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> rtl/otq_engine.sv
// Back end of the ordered timer queue: the slot table, the scanning sequencer
// that carries out each command, and the result output register.
// Depends on otq_pkg.
module otq_engine import otq_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW:0]   SLOTS_C = (IW + 1)'(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // Deadline and period memories.
    logic [63:0] dl_mem  [0:SLOTS-1];
    logic [63:0] per_mem [0:SLOTS-1];
    logic        dl_we, per_we;
    logic [IW-1:0] dl_wa;
    logic [63:0] dl_wd;
    logic [63:0] dl_rd_reg, per_rd_reg;

    state_t      state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [SLOTS-1:0] act_reg, act_next, rec_reg, rec_next, pend_reg, pend_next;
    logic [IW-1:0] free_reg, free_next, best_i_reg, best_i_next;
    logic [63:0] dl_reg, dl_next, best_reg, best_next;
    logic        have_reg, have_next, front_reg, front_next;
    logic        first_reg, first_next, more_reg, more_next;
    logic [IW:0] scan_cnt_reg, scan_cnt_next, cnt_reg, cnt_next;
    logic        ev_valid_reg, ev_valid_next;
    logic [IW-1:0] ev_idx_reg;
    logic [4:0]  n_reg, n_next, total_reg, total_next;
    out_t        res_reg, res_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    logic          out_free;
    logic          any_free;
    logic [IW-1:0] free_idx;
    logic [6:0]    h7, b7, c7;
    logic [IW-1:0] h_idx;
    logic [4:0]    tot_calc;
    logic          cand, is_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cmd_ready = (state_reg == S_IDLE);

    // Lowest free slot.
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!act_reg[i]) begin
                any_free = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // Index conversions between the 4-bit handle and slot indexes.
    always_comb begin
        h7    = 7'(cmd.handle);
        h_idx = h7[IW-1:0];
        b7    = 7'(best_i_reg);
        c7    = 7'(cnt_reg);
        tot_calc = (c7 >= 7'(MAX_RESULTS)) ? 5'(MAX_RESULTS) : c7[4:0];
        cand  = act_reg[ev_idx_reg] && pend_reg[ev_idx_reg] && (dl_rd_reg <= cmd_reg.now_us);
        is_last = ((n_reg + 5'd1) == total_reg);
    end

    // Sequencer: next state, table updates and results.
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        act_next      = act_reg;
        rec_next      = rec_reg;
        pend_next     = pend_reg;
        free_next     = free_reg;
        best_i_next   = best_i_reg;
        dl_next       = dl_reg;
        best_next     = best_reg;
        have_next     = have_reg;
        front_next    = front_reg;
        first_next    = first_reg;
        more_next     = more_reg;
        scan_cnt_next = scan_cnt_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        total_next    = total_reg;
        res_next      = res_reg;
        m_valid_next  = m_ready ? 1'b0 : m_valid_reg;
        m_data_next   = m_data_reg;
        ev_valid_next = (state_reg == S_SCAN) && (scan_cnt_reg < SLOTS_C);
        dl_we         = 1'b0;
        per_we        = 1'b0;
        dl_wa         = free_reg;
        dl_wd         = dl_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_next      = cmd;
                    res_next      = '0;
                    res_next.last = 1'b1;
                    scan_cnt_next = '0;
                    have_next     = 1'b0;
                    front_next    = 1'b1;
                    cnt_next      = '0;
                    more_next     = 1'b0;
                    unique case (cmd.op)
                        OP_REGISTER: begin
                            if (any_free) begin
                                free_next  = free_idx;
                                state_next = S_REG_ADD;
                            end else begin
                                res_next.status = ST_FULL;
                                state_next      = S_OUT;
                            end
                        end
                        OP_CANCEL: begin
                            res_next.handle_out = cmd.handle;
                            if (cmd.in_range && act_reg[h_idx]) begin
                                act_next[h_idx] = 1'b0;
                                rec_next[h_idx] = 1'b0;
                            end else begin
                                res_next.status = ST_NOT_ACTIVE;
                            end
                            state_next = S_OUT;
                        end
                        OP_QUERY: begin
                            state_next = S_SCAN;
                        end
                        default: begin
                            pend_next  = '1;
                            n_next     = '0;
                            first_next = 1'b1;
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_REG_ADD: begin
                dl_next    = sat_add(cmd_reg.now_us, cmd_reg.period_us);
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (scan_cnt_reg < SLOTS_C) begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                // Evaluate the slot whose deadline was read last cycle.
                if (ev_valid_reg) begin
                    case (cmd_reg.op)
                        OP_REGISTER: begin
                            if (act_reg[ev_idx_reg] && !((dl_reg < dl_rd_reg) ||
                                ((dl_reg == dl_rd_reg) && (free_reg < ev_idx_reg)))) begin
                                front_next = 1'b0;
                            end
                        end
                        OP_QUERY: begin
                            if (act_reg[ev_idx_reg] && (!have_reg || dl_rd_reg < best_reg)) begin
                                best_next = dl_rd_reg;
                                have_next = 1'b1;
                            end
                        end
                        default: begin
                            if (cand) begin
                                cnt_next = cnt_reg + 1'b1;
                                if (!have_reg || dl_rd_reg < best_reg) begin
                                    best_next   = dl_rd_reg;
                                    best_i_next = ev_idx_reg;
                                    have_next   = 1'b1;
                                end
                            end
                        end
                    endcase
                    if (ev_idx_reg == LAST_IDX) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                case (cmd_reg.op)
                    OP_REGISTER: begin
                        dl_we               = 1'b1;
                        per_we              = 1'b1;
                        act_next[free_reg]  = 1'b1;
                        rec_next[free_reg]  = cmd_reg.repeat_req;
                        res_next.handle_out = 4'(7'(free_reg));
                        res_next.at_front   = front_reg;
                        state_next          = S_OUT;
                    end
                    OP_QUERY: begin
                        if (!have_reg) begin
                            res_next.remaining_us = '1;
                        end else if (cmd_reg.now_us >= best_reg) begin
                            res_next.remaining_us = '0;
                        end else begin
                            res_next.remaining_us = best_reg - cmd_reg.now_us;
                        end
                        state_next = S_OUT;
                    end
                    default: begin
                        if (first_reg) begin
                            total_next = tot_calc;
                            first_next = 1'b0;
                        end
                        if (first_reg && tot_calc == 5'd0) begin
                            res_next   = '0;
                            res_next.last = 1'b1;
                            state_next = S_OUT;
                        end else begin
                            state_next = S_P_UPD;
                        end
                    end
                endcase
            end
            S_P_UPD: begin
                // Rearm a recurring timer or free a one-shot timer.
                if (rec_reg[best_i_reg]) begin
                    dl_we = 1'b1;
                    dl_wa = best_i_reg;
                    dl_wd = sat_add(cmd_reg.now_us, per_rd_reg);
                end else begin
                    act_next[best_i_reg] = 1'b0;
                end
                pend_next[best_i_reg]  = 1'b0;
                res_next               = '0;
                res_next.handle_out    = b7[3:0];
                res_next.expired_valid = 1'b1;
                res_next.last          = is_last;
                n_next                 = n_reg + 5'd1;
                more_next              = !is_last;
                state_next             = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    if (more_reg) begin
                        scan_cnt_next = '0;
                        have_next     = 1'b0;
                        cnt_next      = '0;
                        state_next    = S_SCAN;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            act_reg      <= '0;
            rec_reg      <= '0;
            m_valid_reg  <= 1'b0;
            ev_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            act_reg      <= act_next;
            rec_reg      <= rec_next;
            m_valid_reg  <= m_valid_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        pend_reg     <= pend_next;
        free_reg     <= free_next;
        best_i_reg   <= best_i_next;
        dl_reg       <= dl_next;
        best_reg     <= best_next;
        have_reg     <= have_next;
        front_reg    <= front_next;
        first_reg    <= first_next;
        more_reg     <= more_next;
        scan_cnt_reg <= scan_cnt_next;
        cnt_reg      <= cnt_next;
        n_reg        <= n_next;
        total_reg    <= total_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
        ev_idx_reg   <= scan_cnt_reg[IW-1:0];
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge aclk) begin
        if (dl_we) begin
            dl_mem[dl_wa] <= dl_wd;
        end
        if (per_we) begin
            per_mem[free_reg] <= cmd_reg.period_us;
        end
        dl_rd_reg  <= dl_mem[scan_cnt_reg[IW-1:0]];
        per_rd_reg <= per_mem[best_i_reg];
    end

    // A process item never handles more than the result limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_P_UPD) |-> (n_reg < 5'(MAX_RESULTS)))
        else $error("process result count over limit");

    // Scan data is only evaluated while scanning.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ev_valid_reg |-> (state_reg == S_SCAN))
        else $error("scan data outside scan");

    // A one-shot timer is freed when it expires.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_P_UPD && !rec_reg[best_i_reg]) |=> !act_reg[$past(best_i_reg)])
        else $error("expired one-shot timer still active");

    // A registered timer occupies its slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && cmd_reg.op == OP_REGISTER) |=> act_reg[$past(free_reg)])
        else $error("registered slot not active");

endmodule

>>> rtl/ordered_timer_queue_top.sv
// Ordered timer queue, top level.
// Items enter on the s_ channel (valid/ready) into a short command queue and
// are carried out by the engine, which scans the slot table once per pass.
// Register and Query each scan all slots once; Cancel does not scan.
// Process takes one pass per expired timer, at most 16 passes, and one
// pass when nothing has expired; each pass scans the deadline memory,
// one slot per cycle.
// Results leave on the m_ channel through an output register; each item's
// final result carries last. While the receiver stalls, the engine holds
// its next result and the command queue still takes up to two items.
// Reset empties the queue and frees every slot at the next clock edge.
// Depends on otq_pkg, otq_front and otq_engine.
module ordered_timer_queue_top import otq_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    otq_front #(
        .SLOTS(SLOTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    otq_engine #(
        .SLOTS(SLOTS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
